### sv/ilie_pkg.sv
`default_nettype none

package ilie_pkg;

	// List capacity and stored word width.
	localparam int DEPTH     = 16;
	localparam int WORD_BITS = 32;

	// Fixed field widths of the stream items.
	localparam int CMD_W   = 3;
	localparam int IDX_W   = 5;
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 5;
	localparam int ERR_W   = 2;

	// Internal widths that follow from the capacity.
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int SLOT_W = $clog2(DEPTH);
	localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;

	// Request codes as they arrive in the cmd field. The spare code is not
	// used by the list; it is answered with no change.
	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND      = 3'd0,
		CMD_REMOVE_LAST = 3'd1,
		CMD_INSERT      = 3'd2,
		CMD_ERASE       = 3'd3,
		CMD_READ        = 3'd4,
		CMD_WRITE       = 3'd5,
		CMD_RESIZE      = 3'd6,
		CMD_SPARE       = 3'd7
	} cmd_t;

	// Result codes reported with every request.
	typedef enum logic [ERR_W-1:0] {
		ERR_NONE  = 2'd0,
		ERR_FULL  = 2'd1,
		ERR_EMPTY = 2'd2,
		ERR_RANGE = 2'd3
	} err_t;

	// Operation broadcast to every cell of the row.
	typedef enum logic [2:0] {
		OP_NONE,
		OP_WRITE,
		OP_SHIFT_UP,
		OP_SHIFT_DOWN,
		OP_FILL
	} cell_op_t;

	// Cells act on slots from lo up (a write on lo alone); a fill stops below hi.
	typedef struct packed {
		cell_op_t               op;
		logic [CNT_W-1:0]       lo;
		logic [CNT_W-1:0]       hi;
		logic [WORD_BITS-1:0]   value;
	} cell_ctl_t;

endpackage

`default_nettype wire

### sv/ilie_cell.sv
`default_nettype none

module ilie_cell
	import ilie_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic [SLOT_W-1:0]     slot,
	input  wire cell_ctl_t             ctl,
	input  wire logic [WORD_BITS-1:0]  prev_data,
	input  wire logic [WORD_BITS-1:0]  next_data,
	output logic      [WORD_BITS-1:0]  data
);

	logic [WORD_BITS-1:0] data_q;
	logic [WORD_BITS-1:0] data_nxt;
	logic                 load;
	logic [CNT_W-1:0]     slot_c;

	assign slot_c = CNT_W'(slot);

	// Each cell decides from its own position whether it keeps its word,
	// takes the broadcast word, or takes a neighbor's word.
	always_comb begin
		load     = 1'b0;
		data_nxt = ctl.value;
		case (ctl.op)
			OP_WRITE: begin
				load = (slot_c == ctl.lo);
			end
			OP_SHIFT_UP: begin
				load     = (slot_c >= ctl.lo);
				data_nxt = (slot_c == ctl.lo) ? ctl.value : prev_data;
			end
			OP_SHIFT_DOWN: begin
				load     = (slot_c >= ctl.lo);
				data_nxt = next_data;
			end
			OP_FILL: begin
				load = (slot_c >= ctl.lo) && (slot_c < ctl.hi);
			end
			default: begin
				load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= data_nxt;
		end
	end

	assign data = data_q;

endmodule

`default_nettype wire

### sv/ilie_chain.sv
`default_nettype none

module ilie_chain
	import ilie_pkg::*;
(
	input  wire logic                  clk,
	input  wire cell_ctl_t             ctl,
	input  wire logic [SLOT_W-1:0]     rd_slot,
	output logic      [WORD_BITS-1:0]  rd_data
);

	logic [WORD_BITS-1:0] cell_data [DEPTH];

	// The row of cells; each one sees the words of both neighbors so that
	// a whole insert or erase shift runs in all cells at once.
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [WORD_BITS-1:0] prev_w;
		logic [WORD_BITS-1:0] next_w;

		if (g == 0) begin : g_first
			assign prev_w = '0;
		end else begin : g_mid_prev
			assign prev_w = cell_data[g-1];
		end

		if (g == DEPTH - 1) begin : g_last
			assign next_w = '0;
		end else begin : g_mid_next
			assign next_w = cell_data[g+1];
		end

		ilie_cell u_cell (
			.clk       (clk),
			.slot      (SLOT_W'(g)),
			.ctl       (ctl),
			.prev_data (prev_w),
			.next_data (next_w),
			.data      (cell_data[g])
		);
	end

	assign rd_data = cell_data[rd_slot];

endmodule

`default_nettype wire

### sv/indexed_list_insert_erase_top.sv
// Channel  Direction  Fields (from bit 0 up)
// s_*      in         tdata: cmd[2:0], index[7:3], value[39:8]
// m_*      out        tdata: read_value[31:0], count[36:32], is_empty[37], error[39:38]
//
// Every request is decoded and applied to the row of cells at the edge
// where it is accepted, and its result enters the output register at
// that edge. Insert and erase shifts and the resize fill run in
// all cells at once. A new request is taken while the output register is
// empty or being read, so a stalled result holds the input side off.
// After reset the list is empty; stored words are undefined until written.
`default_nettype none

module indexed_list_insert_erase_top
	import ilie_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,   // cmd, index, value
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [39:0] m_tdata    // read_value, count, is_empty, error
);

	// Unpacked request fields.
	logic [CMD_W-1:0]     cmd_raw;
	logic [IDX_W-1:0]     index;
	logic [VALUE_W-1:0]   value;

	// List length and the registered result.
	logic [CNT_W-1:0]     len_q;
	logic                 out_valid_q;
	logic [VALUE_W-1:0]   read_value_q;
	logic [COUNT_W-1:0]   count_q;
	logic                 is_empty_q;
	err_t                 error_q;

	// Decode results.
	logic                 accept;
	logic [CMP_W-1:0]     idx_c;
	logic [CMP_W-1:0]     len_c;
	logic                 full;
	logic                 empty;
	logic [CNT_W-1:0]     len_nxt;
	err_t                 err_nxt;
	logic [VALUE_W-1:0]   rd_nxt;
	logic                 do_read;
	cell_ctl_t            ctl;
	logic [WORD_BITS-1:0] rd_data;

	assign cmd_raw = s_tdata[2:0];
	assign index   = s_tdata[7:3];
	assign value   = s_tdata[39:8];

	// The output register parts the two sides: a new request enters while
	// the previous result leaves.
	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign idx_c = CMP_W'(index);
	assign len_c = CMP_W'(len_q);
	assign full  = (len_q >= CNT_W'(DEPTH));
	assign empty = (len_q == '0);

	// Command decode. The checks follow the order of the list rules: a full
	// list is reported before a bad index, an empty one before a bad index.
	// Rejected requests issue no cell operation and keep the length.
	always_comb begin
		len_nxt   = len_q;
		err_nxt   = ERR_NONE;
		do_read   = 1'b0;
		ctl.op    = OP_NONE;
		ctl.lo    = CNT_W'(idx_c);
		ctl.hi    = CNT_W'(idx_c);
		ctl.value = WORD_BITS'(value);
		unique case (cmd_t'(cmd_raw))
			CMD_APPEND: begin
				if (full) begin
					err_nxt = ERR_FULL;
				end else begin
					ctl.op  = OP_WRITE;
					ctl.lo  = len_q;
					len_nxt = len_q + 1'b1;
				end
			end
			CMD_REMOVE_LAST: begin
				if (empty) begin
					err_nxt = ERR_EMPTY;
				end else begin
					len_nxt = len_q - 1'b1;
				end
			end
			CMD_INSERT: begin
				if (full) begin
					err_nxt = ERR_FULL;
				end else if (idx_c > len_c) begin
					err_nxt = ERR_RANGE;
				end else begin
					ctl.op  = OP_SHIFT_UP;
					len_nxt = len_q + 1'b1;
				end
			end
			CMD_ERASE: begin
				if (empty) begin
					err_nxt = ERR_EMPTY;
				end else if (idx_c >= len_c) begin
					err_nxt = ERR_RANGE;
				end else begin
					ctl.op  = OP_SHIFT_DOWN;
					len_nxt = len_q - 1'b1;
				end
			end
			CMD_READ: begin
				if (empty) begin
					err_nxt = ERR_EMPTY;
				end else if (idx_c >= len_c) begin
					err_nxt = ERR_RANGE;
				end else begin
					do_read = 1'b1;
				end
			end
			CMD_WRITE: begin
				if (empty) begin
					err_nxt = ERR_EMPTY;
				end else if (idx_c >= len_c) begin
					err_nxt = ERR_RANGE;
				end else begin
					ctl.op = OP_WRITE;
				end
			end
			CMD_RESIZE: begin
				// Growing fills the slots from the old length up to the new
				// one; shrinking only moves the length down.
				if (idx_c > CMP_W'(DEPTH)) begin
					err_nxt = ERR_RANGE;
				end else begin
					ctl.op  = OP_FILL;
					ctl.lo  = len_q;
					len_nxt = CNT_W'(idx_c);
				end
			end
			default: begin
				// The unused code is answered with no change.
				err_nxt = ERR_NONE;
			end
		endcase
		if (!accept) begin
			ctl.op = OP_NONE;
		end
		rd_nxt = do_read ? VALUE_W'(rd_data) : '0;
	end

	ilie_chain u_chain (
		.clk     (clk),
		.ctl     (ctl),
		.rd_slot (idx_c[SLOT_W-1:0]),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				len_q       <= len_nxt;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			read_value_q <= rd_nxt;
			count_q      <= COUNT_W'(len_nxt);
			is_empty_q   <= (len_nxt == '0);
			error_q      <= err_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {error_q, is_empty_q, count_q, read_value_q};

endmodule

`default_nettype wire
